// ----- rtl/best_match_format_selector_unit_assert.svh -----
// Assertion macros for the best match format selector.
`ifndef BEST_MATCH_FORMAT_SELECTOR_UNIT_ASSERT_SVH
`define BEST_MATCH_FORMAT_SELECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define BMFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("best match format selector: assertion failed");
// Next-cycle implication, checked out of reset.
`define BMFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("best match format selector: assertion failed");
`else
`define BMFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMFS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bmfs_pkg.sv -----
// Types, constants and the count rule shared by the format selector.
`timescale 1ns / 1ps
package bmfs_pkg;

  typedef struct packed {
    logic [15:0] index;
    logic [3:0]  buffers;
    logic [5:0]  color;
    logic [4:0]  alpha;
    logic [5:0]  depth;
    logic [4:0]  stencil;
    logic [5:0]  samples;
    logic [1:0]  swap;
    logic        offscreen;
    logic        window;
    logic        stereo;
  } cand_t;

  typedef struct packed {
    logic [3:0] buffers;
    logic [5:0] color;
    logic [4:0] alpha;
    logic [5:0] depth;
    logic [4:0] stencil;
    logic [5:0] samples;
    logic [1:0] swap;
  } req_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_REQ_BUFFERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_DEPTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_STENCIL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_SAMPLES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_SWAP    = 3'd6;

  localparam req_t REQ_RESET = '{buffers: 4'd2, color: 6'd24, alpha: 5'd8, depth: 6'd24,
                                 stencil: 5'd8, samples: 6'd0, swap: 2'd0};

  localparam logic [3:0]  DOUBLE_BUF_MIN = 4'd2;
  localparam logic [3:0]  SINGLE_BUF     = 4'd1;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  // True when the new value b beats the held value a; only meaningful when a != b.
  function automatic logic count_new_wins(input logic [5:0] a, input logic [5:0] b,
                                          input logic [5:0] want);
    logic r;
    if (a == want) begin
      r = 1'b0;
    end else if (b == want) begin
      r = 1'b1;
    end else if (a < want) begin
      r = (b < want) ? (a < b) : 1'b1;
    end else begin
      r = (b > want) ? (a > b) : 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/bmfs_cfg_regs.sv -----
// Request register file written through the plain configuration port.
`timescale 1ns / 1ps
module bmfs_cfg_regs
  import bmfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output req_t                  req
);

  req_t req_r;
  req_t req_nxt;

  always_comb begin
    req_nxt = req_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_REQ_BUFFERS: req_nxt.buffers = cfg_wdata[3:0];
        CFG_REQ_COLOR:   req_nxt.color   = cfg_wdata[5:0];
        CFG_REQ_ALPHA:   req_nxt.alpha   = cfg_wdata[4:0];
        CFG_REQ_DEPTH:   req_nxt.depth   = cfg_wdata[5:0];
        CFG_REQ_STENCIL: req_nxt.stencil = cfg_wdata[4:0];
        CFG_REQ_SAMPLES: req_nxt.samples = cfg_wdata[5:0];
        CFG_REQ_SWAP:    req_nxt.swap    = cfg_wdata[1:0];
        default:         req_nxt = req_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= REQ_RESET;
    end else begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

// ----- rtl/bmfs_compare.sv -----
// Priority comparison of a new candidate against the held best.
`timescale 1ns / 1ps
module bmfs_compare
  import bmfs_pkg::*;
(
  input  cand_t hold,
  input  cand_t cand,
  input  req_t  req,
  output logic  new_wins
);

  logic buf_decided;
  logic buf_new;

  // Double buffering preference, which may leave the decision open.
  always_comb begin
    buf_decided = 1'b0;
    buf_new     = 1'b0;
    if (hold.buffers != cand.buffers) begin
      if (req.buffers < DOUBLE_BUF_MIN) begin
        if (hold.buffers == SINGLE_BUF) begin
          buf_decided = 1'b1;
        end else if (cand.buffers == SINGLE_BUF) begin
          buf_decided = 1'b1;
          buf_new     = 1'b1;
        end
      end else begin
        if (hold.buffers >= DOUBLE_BUF_MIN && cand.buffers < DOUBLE_BUF_MIN) begin
          buf_decided = 1'b1;
        end else if (hold.buffers < DOUBLE_BUF_MIN && cand.buffers >= DOUBLE_BUF_MIN) begin
          buf_decided = 1'b1;
          buf_new     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (buf_decided) begin
      new_wins = buf_new;
    end else if (hold.color != cand.color) begin
      new_wins = count_new_wins(hold.color, cand.color, req.color);
    end else if (hold.depth != cand.depth) begin
      new_wins = count_new_wins(hold.depth, cand.depth, req.depth);
    end else if (hold.stencil != cand.stencil) begin
      new_wins = count_new_wins({1'b0, hold.stencil}, {1'b0, cand.stencil},
                                {1'b0, req.stencil});
    end else if (hold.samples != cand.samples) begin
      new_wins = count_new_wins(hold.samples, cand.samples, req.samples);
    end else if (hold.alpha != cand.alpha) begin
      new_wins = count_new_wins({1'b0, hold.alpha}, {1'b0, cand.alpha}, {1'b0, req.alpha});
    end else if (hold.swap != cand.swap && hold.swap == req.swap) begin
      new_wins = 1'b0;
    end else if (hold.swap != cand.swap && cand.swap == req.swap) begin
      new_wins = 1'b1;
    end else if (hold.buffers != cand.buffers) begin
      new_wins = count_new_wins({2'b00, hold.buffers}, {2'b00, cand.buffers},
                                {2'b00, req.buffers});
    end else if (hold.offscreen != cand.offscreen) begin
      new_wins = cand.offscreen;
    end else if (hold.window != cand.window) begin
      new_wins = cand.window;
    end else if (hold.stereo != cand.stereo) begin
      new_wins = cand.stereo;
    end else begin
      new_wins = 1'b1;
    end
  end

endmodule

// ----- rtl/best_match_format_selector_unit.sv -----
// Top level of the best match format selector.
`timescale 1ns / 1ps
// The selector takes one candidate format word per clock cycle while in_stall
// is low and keeps the candidate that best matches the request registers. A
// word enters an input register when accepted and is compared in the next
// cycle against the held best; that comparison against the best register sets
// the rate of one word per cycle. A word marked last produces one result word
// (best index and run length, the length saturating at 65535) in the result
// register when it leaves the input register. The result register parts the
// two sides: words that do not end a run keep flowing while a result waits,
// and only a last word meeting a stalled, occupied result register holds the
// input side. The user must write the request registers only while the block
// is idle; the block itself does not enforce this.
`include "best_match_format_selector_unit_assert.svh"
module best_match_format_selector_unit
  import bmfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_fmt_index,
  input  logic [3:0]            in_buffers,
  input  logic [5:0]            in_color_bits,
  input  logic [4:0]            in_alpha_bits,
  input  logic [5:0]            in_depth_bits,
  input  logic [4:0]            in_stencil_bits,
  input  logic [5:0]            in_samples,
  input  logic [1:0]            in_swap_method,
  input  logic                  in_offscreen_ok,
  input  logic                  in_window_ok,
  input  logic                  in_stereo_ok,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_best_index,
  output logic [15:0]           out_run_length
);

  req_t        req;
  cand_t       s1_cand_r;
  logic        s1_last_r;
  logic        s1_valid_r;
  cand_t       best_r;
  logic        have_best_r;
  logic [15:0] seen_r;
  logic        out_valid_r;
  logic [15:0] out_best_index_r;
  logic [15:0] out_run_length_r;

  logic        new_wins;
  logic        take;
  logic        advance;
  logic        in_accept;
  cand_t       best_nxt;
  logic [15:0] seen_nxt;

  bmfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req)
  );

  bmfs_compare u_cmp (
    .hold     (best_r),
    .cand     (s1_cand_r),
    .req      (req),
    .new_wins (new_wins)
  );

  // The staged word moves on unless it ends a run and the result register is
  // still full and stalled.
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // The first word of a run is taken as best without comparison.
  assign take     = !have_best_r || new_wins;
  assign best_nxt = take ? s1_cand_r : best_r;
  assign seen_nxt = (seen_r == COUNT_MAX) ? seen_r : seen_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cand_r <= '{index: in_fmt_index, buffers: in_buffers, color: in_color_bits,
                     alpha: in_alpha_bits, depth: in_depth_bits,
                     stencil: in_stencil_bits, samples: in_samples,
                     swap: in_swap_method, offscreen: in_offscreen_ok,
                     window: in_window_ok, stereo: in_stereo_ok};
      s1_last_r <= in_is_last;
    end
  end

  // Run state: cleared once the last word has been folded in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      seen_r      <= 16'd0;
    end else if (advance) begin
      have_best_r <= !s1_last_r;
      seen_r      <= s1_last_r ? 16'd0 : seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_best_index_r <= best_nxt.index;
      out_run_length_r <= seen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_best_index_r;
  assign out_run_length = out_run_length_r;

  // A best is held exactly while the run count is non-zero.
  `BMFS_ASSERT_IMP(a_best_tracks_count, clk, rst_n, 1'b1, have_best_r == (seen_r != 16'd0))
  // The input side only holds for a last word behind a stalled, full result.
  `BMFS_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
                   s1_valid_r && s1_last_r && out_valid_r && out_stall)
  // Closing a run loads a result and clears the run state.
  `BMFS_ASSERT_NXT(a_run_close, clk, rst_n, advance && s1_last_r,
                   out_valid_r && !have_best_r && seen_r == 16'd0)

endmodule
